// ===== hdl/epnf_pkg.sv =====
package epnf_pkg;

  localparam int MAX_WIDTH   = 1024;
  localparam int MAX_HEIGHT  = 512;
  localparam int PIXEL_BITS  = 8;

  // Fixed widths of the frame size registers
  localparam int WIDTH_BITS  = 11;
  localparam int HEIGHT_BITS = 10;
  localparam int CFG_BITS    = WIDTH_BITS;
  localparam int CFG_IDX_BITS = 1;

  localparam int WIDTH_RESET  = 256;
  localparam int HEIGHT_RESET = 256;

  localparam int COL_BITS = $clog2(MAX_WIDTH);
  // input row runs up to height + 1 while draining
  localparam int ROW_BITS = $clog2(MAX_HEIGHT + 2);

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_FRAME_WIDTH  = 1'b0,
    CFG_FRAME_HEIGHT = 1'b1
  } cfg_reg_e;

  typedef logic [PIXEL_BITS-1:0] pix_t;
  // index 0 = upper row, 1 = middle row, 2 = lower row
  typedef pix_t [2:0] col_t;

  typedef struct packed {
    pix_t pixel_in;
    logic flush;
  } in_item_t;

  typedef struct packed {
    pix_t pixel_out;
    logic was_filled;
    logic last_of_frame;
  } out_item_t;

  // One accepted item as it enters the window stage
  typedef struct packed {
    pix_t                pix;
    logic [COL_BITS-1:0] col;
    logic                wr;
    logic                out;
    logic                last;
    logic                top_ok;
    logic                bot_ok;
    logic                left_ok;
    logic                right_ok;
    pix_t                empty;
  } job_t;

  typedef struct packed {
    logic                en;
    logic [COL_BITS-1:0] addr;
    pix_t                upper;
    pix_t                middle;
  } lb_wr_t;

  typedef struct packed {
    pix_t upper;
    pix_t middle;
  } lb_rd_t;

  typedef struct packed {
    logic s1_ready;
    logic s1_go;
  } fill_stat_t;

endpackage

// ===== hdl/empty_pixel_neighbor_fill.sv =====
// Empty pixel neighbor fill over one raster-order frame of indexed pixels.
//
// Input channel (in_valid_i / in_stall_o / in_item_i): one pixel per item in
// raster order. The first pixel of a frame sets the empty value and samples
// frame_width / frame_height. After the last pixel, feed flush items (or any
// items) to drain; flush items sent while pixels are still due are dropped.
// Output channel (out_valid_o / out_stall_i / out_item_o): one filled pixel per
// item, raster order, last_of_frame on the final one.
// Config port: cfg_we_i writes cfg_idx_i (0 width, 1 height) while idle.
//
// Throughput is one item per cycle while no stall holds the window stage.
// The result produced by an item is the pixel one row plus one pixel behind
// it; the accepting edge loads the window stage, and the window stage then
// loads the output register. The line stores are read at the accepting edge
// and rewritten from the window stage; a same-column write at that edge is
// forwarded. A stalled output only stalls the input when the window stage
// also holds a result; other items keep flowing. Reset clears counters, the
// window and the valid flags and sets the size registers to 256 x 256; line
// stores are not cleared and need no clearing pass.
module empty_pixel_neighbor_fill (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [epnf_pkg::CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [epnf_pkg::CFG_BITS-1:0]      cfg_wdata_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  epnf_pkg::in_item_t                 in_item_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output epnf_pkg::out_item_t                out_item_o
);

  logic                 accept;
  epnf_pkg::job_t       job;
  logic                 job_valid;
  epnf_pkg::lb_rd_t     lb_rd;
  epnf_pkg::lb_wr_t     lb_wr;
  epnf_pkg::fill_stat_t fill_stat;

  // an item enters whenever the window stage can take it
  assign accept     = in_valid_i && fill_stat.s1_ready;
  assign in_stall_o = !fill_stat.s1_ready;

  // position counters, frame sizing, empty value, flush filtering
  epnf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .accept_i    (accept),
    .item_i      (in_item_i),
    .job_o       (job),
    .job_valid_o (job_valid)
  );

  // two rows of history, indexed by column
  epnf_lbuf u_lbuf (
    .clk_i     (clk_i),
    .rd_en_i   (accept),
    .rd_addr_i (job.col),
    .rd_o      (lb_rd),
    .wr_i      (lb_wr)
  );

  // 3x3 window, priority fill and output register
  epnf_fill u_fill (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (accept && job_valid),
    .job_i       (job),
    .rd_i        (lb_rd),
    .wr_o        (lb_wr),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o),
    .stat_o      (fill_stat)
  );

  // input backs up only behind a blocked output register
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a blocked output");

  // a new result comes only from a job leaving the window stage
  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(fill_stat.s1_go))
    else $error("result appeared without a window stage move");

  // a store write never happens without a job in the window stage
  a_wr_gate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lb_wr.en |-> fill_stat.s1_go)
    else $error("line store written outside a window stage move");

endmodule

// ===== hdl/epnf_ctrl.sv =====
module epnf_ctrl (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [epnf_pkg::CFG_IDX_BITS-1:0]   cfg_idx_i,
  input  logic [epnf_pkg::CFG_BITS-1:0]       cfg_wdata_i,
  input  logic                                accept_i,
  input  epnf_pkg::in_item_t                  item_i,
  output epnf_pkg::job_t                      job_o,
  output logic                                job_valid_o
);

  localparam int WB = epnf_pkg::WIDTH_BITS;
  localparam int HB = epnf_pkg::HEIGHT_BITS;
  localparam int CB = epnf_pkg::COL_BITS;
  localparam int RB = epnf_pkg::ROW_BITS;

  logic [WB-1:0] frame_width_q;
  logic [HB-1:0] frame_height_q;
  logic [WB-1:0] act_w_q;
  logic [HB-1:0] act_h_q;
  epnf_pkg::pix_t empty_q;
  logic [CB-1:0] in_col_q, in_col_d, out_col_q, out_col_d;
  logic [RB-1:0] in_row_q, in_row_d, out_row_q, out_row_d;

  logic [WB-1:0] clamp_w, eff_w, in_col_inc, out_col_inc;
  logic [HB-1:0] clamp_h, eff_h;
  logic [RB:0]   out_row_inc;
  logic          start, in_frame, ignore, produce, last;

  always_comb begin
    if (frame_width_q == '0) clamp_w = WB'(1);
    else if (frame_width_q > WB'(epnf_pkg::MAX_WIDTH)) clamp_w = WB'(epnf_pkg::MAX_WIDTH);
    else clamp_w = frame_width_q;
    if (frame_height_q == '0) clamp_h = HB'(1);
    else if (frame_height_q > HB'(epnf_pkg::MAX_HEIGHT)) clamp_h = HB'(epnf_pkg::MAX_HEIGHT);
    else clamp_h = frame_height_q;
  end

  // Frame size is sampled with the first pixel of a frame
  assign start = (in_col_q == '0) && (in_row_q == '0) && (out_col_q == '0) && (out_row_q == '0);
  assign eff_w = start ? clamp_w : act_w_q;
  assign eff_h = start ? clamp_h : act_h_q;

  assign in_frame = RB'(in_row_q) < RB'(eff_h);
  assign ignore   = item_i.flush && in_frame;
  // linear input index has reached width + 1
  assign produce  = (in_row_q >= RB'(2)) || ((in_row_q == RB'(1)) && (in_col_q != '0));
  assign last     = (RB'(out_row_q) == RB'(eff_h - HB'(1))) &&
                    (WB'(out_col_q) == eff_w - WB'(1));

  assign in_col_inc  = WB'(in_col_q) + WB'(1);
  assign out_col_inc = WB'(out_col_q) + WB'(1);
  assign out_row_inc = (RB + 1)'(out_row_q) + (RB + 1)'(1);

  always_comb begin
    in_col_d  = in_col_q;
    in_row_d  = in_row_q;
    out_col_d = out_col_q;
    out_row_d = out_row_q;
    if (produce && last) begin
      in_col_d  = '0;
      in_row_d  = '0;
      out_col_d = '0;
      out_row_d = '0;
    end else begin
      if (in_col_inc >= eff_w) begin
        in_col_d = '0;
        in_row_d = in_row_q + RB'(1);
      end else begin
        in_col_d = in_col_inc[CB-1:0];
      end
      if (produce) begin
        if (out_col_inc >= eff_w) begin
          out_col_d = '0;
          out_row_d = out_row_q + RB'(1);
        end else begin
          out_col_d = out_col_inc[CB-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= WB'(epnf_pkg::WIDTH_RESET);
      frame_height_q <= HB'(epnf_pkg::HEIGHT_RESET);
      act_w_q        <= WB'(1);
      act_h_q        <= HB'(1);
      empty_q        <= '0;
      in_col_q       <= '0;
      in_row_q       <= '0;
      out_col_q      <= '0;
      out_row_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (epnf_pkg::cfg_reg_e'(cfg_idx_i))
          epnf_pkg::CFG_FRAME_WIDTH:  frame_width_q  <= cfg_wdata_i[WB-1:0];
          epnf_pkg::CFG_FRAME_HEIGHT: frame_height_q <= cfg_wdata_i[HB-1:0];
          default: ;
        endcase
      end
      if (accept_i && !ignore) begin
        if (start) begin
          act_w_q <= clamp_w;
          act_h_q <= clamp_h;
          empty_q <= item_i.pixel_in;
        end
        in_col_q  <= in_col_d;
        in_row_q  <= in_row_d;
        out_col_q <= out_col_d;
        out_row_q <= out_row_d;
      end
    end
  end

  assign job_valid_o    = !ignore;
  assign job_o.pix      = item_i.pixel_in;
  assign job_o.col      = in_col_q;
  assign job_o.wr       = in_frame;
  assign job_o.out      = produce;
  assign job_o.last     = last;
  assign job_o.top_ok   = out_row_q != '0;
  assign job_o.bot_ok   = out_row_inc < (RB + 1)'(eff_h);
  assign job_o.left_ok  = out_col_q != '0;
  assign job_o.right_ok = out_col_inc < eff_w;
  assign job_o.empty    = start ? item_i.pixel_in : empty_q;

endmodule

// ===== hdl/epnf_lbuf.sv =====
module epnf_lbuf (
  input  logic                           clk_i,
  input  logic                           rd_en_i,
  input  logic [epnf_pkg::COL_BITS-1:0]  rd_addr_i,
  output epnf_pkg::lb_rd_t               rd_o,
  input  epnf_pkg::lb_wr_t               wr_i
);

  epnf_pkg::pix_t line_store_upper  [epnf_pkg::MAX_WIDTH];
  epnf_pkg::pix_t line_store_middle [epnf_pkg::MAX_WIDTH];
  epnf_pkg::lb_rd_t rd_q;

  // read-during-write returns the old entry; the window stage forwards
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      line_store_upper[wr_i.addr]  <= wr_i.upper;
      line_store_middle[wr_i.addr] <= wr_i.middle;
    end
    if (rd_en_i) begin
      rd_q.upper  <= line_store_upper[rd_addr_i];
      rd_q.middle <= line_store_middle[rd_addr_i];
    end
  end

  assign rd_o = rd_q;

endmodule

// ===== hdl/epnf_fill.sv =====
module epnf_fill (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    load_i,
  input  epnf_pkg::job_t          job_i,
  input  epnf_pkg::lb_rd_t        rd_i,
  output epnf_pkg::lb_wr_t        wr_o,
  input  logic                    out_stall_i,
  output logic                    out_valid_o,
  output epnf_pkg::out_item_t     out_item_o,
  output epnf_pkg::fill_stat_t    stat_o
);

  logic                s1_valid_q;
  epnf_pkg::job_t      s1_q;
  logic                fwd_q;
  epnf_pkg::lb_rd_t    fwd_data_q;
  epnf_pkg::col_t      win_q [3];
  epnf_pkg::col_t      win_d [3];
  epnf_pkg::col_t      new_col;
  logic                out_valid_q;
  epnf_pkg::out_item_t out_item_q;
  epnf_pkg::out_item_t res;
  logic                out_free, s1_go, s1_ready;
  logic [2:0]          col_ok, row_ok;
  logic                found;
  epnf_pkg::pix_t      pick;

  assign out_free = !out_valid_q || !out_stall_i;
  assign s1_go    = s1_valid_q && (!s1_q.out || out_free);
  assign s1_ready = !s1_valid_q || s1_go;

  // column entering the window: rows r-2, r-1 from the stores, row r live
  assign new_col[0] = fwd_q ? fwd_data_q.upper  : rd_i.upper;
  assign new_col[1] = fwd_q ? fwd_data_q.middle : rd_i.middle;
  assign new_col[2] = s1_q.pix;

  assign win_d[0] = win_q[1];
  assign win_d[1] = win_q[2];
  assign win_d[2] = new_col;

  // store rotates: upper takes the old middle, middle takes the new pixel
  assign wr_o.en     = s1_go && s1_q.wr;
  assign wr_o.addr   = s1_q.col;
  assign wr_o.upper  = new_col[1];
  assign wr_o.middle = s1_q.pix;

  assign col_ok = {s1_q.right_ok, 1'b1, s1_q.left_ok};
  assign row_ok = {s1_q.bot_ok, 1'b1, s1_q.top_ok};

  // column offset outer, row offset inner, first non-empty wins
  always_comb begin
    found = 1'b0;
    pick  = win_d[1][1];
    for (int dx = 0; dx < 3; dx++) begin
      for (int dy = 0; dy < 3; dy++) begin
        if (!found && col_ok[dx] && row_ok[dy] && (win_d[dx][dy] != s1_q.empty)) begin
          found = 1'b1;
          pick  = win_d[dx][dy];
        end
      end
    end
  end

  always_comb begin
    res.last_of_frame = s1_q.last;
    if (win_d[1][1] == s1_q.empty) begin
      res.pixel_out  = pick;
      res.was_filled = found;
    end else begin
      res.pixel_out  = win_d[1][1];
      res.was_filled = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        win_q[i] <= '0;
      end
    end else begin
      if (s1_ready) begin
        s1_valid_q <= load_i;
      end
      if (s1_go) begin
        win_q <= win_d;
      end
      if (s1_go && s1_q.out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready) begin
      s1_q       <= job_i;
      fwd_q      <= wr_o.en && (wr_o.addr == job_i.col);
      fwd_data_q <= '{upper: wr_o.upper, middle: wr_o.middle};
    end
    if (s1_go && s1_q.out) begin
      out_item_q <= res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_item_o      = out_item_q;
  assign stat_o.s1_ready = s1_ready;
  assign stat_o.s1_go    = s1_go;

endmodule

// ===== tb/sv/fill_checker.sv =====
`timescale 1ns / 100ps

module fill_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [epnf_pkg::CFG_IDX_BITS-1:0] cfg_idx_i,
  input  logic [epnf_pkg::CFG_BITS-1:0]     cfg_wdata_i,
  input  logic                              in_valid_i,
  input  logic                              in_stall_i,
  input  epnf_pkg::in_item_t                in_item_i,
  input  logic                              out_valid_i,
  input  logic                              out_stall_i,
  input  epnf_pkg::out_item_t               out_item_i,
  output int                                fail_count_o,
  output int                                pending_o,
  output int                                checked_o
);

  localparam int MAX_REPORTS = 100;

  // original (unfilled) rows, picked by row mod 3
  epnf_pkg::pix_t      orig_rows [3][epnf_pkg::MAX_WIDTH];
  int unsigned         width_reg, height_reg;
  int unsigned         frame_w, frame_h;
  int unsigned         col_n, row_n, emitted;
  epnf_pkg::pix_t      blank_val;
  epnf_pkg::out_item_t expected_pixels_q [$];
  epnf_pkg::out_item_t want;
  int                  fails, checked;

  function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  // pixel arriving right now is bypassed, older ones come from the rows
  function automatic epnf_pkg::pix_t orig_pixel(int r, int c, int unsigned q,
                                                int unsigned total,
                                                epnf_pkg::pix_t cur);
    int unsigned lin;
    lin = r * frame_w + c;
    if (lin == q && q < total) return cur;
    return orig_rows[r % 3][c];
  endfunction

  function automatic void predict_fill(epnf_pkg::in_item_t it);
    int unsigned         total, q;
    int                  ro, co, nr, nc;
    epnf_pkg::pix_t      win [3][3];
    logic                on_frame [3][3];
    epnf_pkg::pix_t      res;
    logic                filled;
    epnf_pkg::out_item_t res_item;
    if (row_n == 0 && col_n == 0 && emitted == 0) begin
      if (it.flush) return;
      frame_w   = clamp_dim(width_reg, epnf_pkg::MAX_WIDTH);
      frame_h   = clamp_dim(height_reg, epnf_pkg::MAX_HEIGHT);
      blank_val = it.pixel_in;
    end
    total = frame_w * frame_h;
    q     = row_n * frame_w + col_n;
    if (it.flush && q < total) return;

    if (q >= frame_w + 1 && emitted < total) begin
      ro = int'(emitted / frame_w);
      co = int'(emitted % frame_w);
      for (int dx = 0; dx < 3; dx++) begin
        for (int dy = 0; dy < 3; dy++) begin
          nr = ro + dy - 1;
          nc = co + dx - 1;
          on_frame[dy][dx] = nr >= 0 && nr < int'(frame_h) && nc >= 0 && nc < int'(frame_w);
          win[dy][dx] = on_frame[dy][dx] ? orig_pixel(nr, nc, q, total, it.pixel_in) : '0;
        end
      end
      res    = win[1][1];
      filled = 1'b0;
      // column offset outer, row offset inner; first hit wins
      if (res == blank_val) begin
        for (int dx = 0; dx < 3; dx++) begin
          for (int dy = 0; dy < 3; dy++) begin
            if (!filled && on_frame[dy][dx] && win[dy][dx] != blank_val) begin
              res    = win[dy][dx];
              filled = 1'b1;
            end
          end
        end
      end
      res_item.pixel_out     = res;
      res_item.was_filled    = filled;
      res_item.last_of_frame = (emitted == total - 1);
      expected_pixels_q.push_back(res_item);
      emitted++;
    end

    if (q < total) orig_rows[row_n % 3][col_n] = it.pixel_in;
    col_n++;
    if (col_n >= frame_w) begin
      col_n = 0;
      row_n++;
    end
    if (emitted >= total) begin
      col_n   = 0;
      row_n   = 0;
      emitted = 0;
    end
  endfunction

  task automatic flag_field(string name, int unsigned want_v, int unsigned got_v);
    fails++;
    if (fails <= MAX_REPORTS)
      $display("%0t fill_checker: %s mismatch, expected %0h, got %0h",
               $time, name, want_v, got_v);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_reg  = epnf_pkg::WIDTH_RESET;
      height_reg = epnf_pkg::HEIGHT_RESET;
      frame_w    = 1;
      frame_h    = 1;
      col_n      = 0;
      row_n      = 0;
      emitted    = 0;
      blank_val  = '0;
      expected_pixels_q.delete();
    end else begin
      // results leave only after the edge that accepts their item, so compare first
      if (out_valid_i && !out_stall_i) begin
        if (expected_pixels_q.size() == 0) begin
          fails++;
          if (fails <= MAX_REPORTS)
            $display("%0t fill_checker: unexpected item, expected none, got %02h/%b/%b",
                     $time, out_item_i.pixel_out, out_item_i.was_filled,
                     out_item_i.last_of_frame);
        end else begin
          want = expected_pixels_q.pop_front();
          checked++;
          if (out_item_i.pixel_out !== want.pixel_out)
            flag_field("pixel_out", want.pixel_out, out_item_i.pixel_out);
          if (out_item_i.was_filled !== want.was_filled)
            flag_field("was_filled", want.was_filled, out_item_i.was_filled);
          if (out_item_i.last_of_frame !== want.last_of_frame)
            flag_field("last_of_frame", want.last_of_frame, out_item_i.last_of_frame);
        end
      end
      if (in_valid_i && !in_stall_i) predict_fill(in_item_i);
      if (cfg_we_i) begin
        case (cfg_idx_i)
          epnf_pkg::CFG_FRAME_WIDTH:
            width_reg  = cfg_wdata_i[epnf_pkg::WIDTH_BITS-1:0];
          epnf_pkg::CFG_FRAME_HEIGHT:
            height_reg = cfg_wdata_i[epnf_pkg::HEIGHT_BITS-1:0];
          default: ;
        endcase
      end
    end
    pending_o    <= expected_pixels_q.size();
    fail_count_o <= fails;
    checked_o    <= checked;
  end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps

module tb;

  localparam int CLK_HALF     = 5;       // 10 ns period
  localparam int RESET_CYCLES = 10;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int PHASE_ITEMS  = 180;     // random items per stall mix
  localparam int SETTLE       = 4;       // window stage + output register, with margin

  typedef epnf_pkg::pix_t pix_q_t [$];

  logic                              clk = 1'b0;
  logic                              rst_n;
  logic                              cfg_we;
  logic [epnf_pkg::CFG_IDX_BITS-1:0] cfg_idx;
  logic [epnf_pkg::CFG_BITS-1:0]     cfg_wdata;
  logic                              in_valid;
  logic                              in_stall;
  epnf_pkg::in_item_t                in_item;
  logic                              out_valid;
  logic                              out_stall;
  epnf_pkg::out_item_t               out_item;

  int          fail_count, pending, checked;
  int          tx_idle_pct = 35;
  int          rx_idle_pct = 55;
  int unsigned eff_w, eff_h;   // frame size the block will latch at frame start
  int          items_sent  = 0;
  int          frames_sent = 0;
  int          cycles      = 0;
  pix_q_t      frame_px;       // pixels of the next frame, raster order
  int          fill_mix [4] = '{0, 50, 85, 100};  // percent of blank pixels

  empty_pixel_neighbor_fill u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item)
  );

  fill_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_item_i    (in_item),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_item_i   (out_item),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  always #CLK_HALF clk = ~clk;

  // watchdog: a hang or a lost result ends here
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // receiver side: random back-pressure, independent of valid
  always @(posedge clk) begin
    out_stall <= (rx_idle_pct != 0) && ($urandom_range(99) < rx_idle_pct);
  end

  // same clamping the block applies when it latches the size
  function automatic int unsigned frame_dim(int unsigned v, int unsigned hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  // Offer one item, with random sender gaps first. Returns in the step of
  // the accepting edge; valid is left high so the next item can follow
  // back to back.
  task automatic send_item(epnf_pkg::in_item_t it);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  // Hold off the sender until every predicted result has left the block.
  // The first edge lets the checker count an item accepted in this step.
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Both size registers, written back to back while idle.
  task automatic set_size(int unsigned w, int unsigned h);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_idx   <= epnf_pkg::CFG_FRAME_WIDTH;
    cfg_wdata <= epnf_pkg::CFG_BITS'(w);
    @(posedge clk);
    cfg_idx   <= epnf_pkg::CFG_FRAME_HEIGHT;
    cfg_wdata <= epnf_pkg::CFG_BITS'(h);
    @(posedge clk);
    cfg_we    <= 1'b0;
    eff_w = frame_dim(w, epnf_pkg::MAX_WIDTH);
    eff_h = frame_dim(h, epnf_pkg::MAX_HEIGHT);
  endtask

  // First pixel sets the blank value; pct says how many others repeat it.
  task automatic make_frame(int pct);
    epnf_pkg::pix_t blank;
    frame_px.delete();
    blank = epnf_pkg::pix_t'($urandom);
    frame_px.push_back(blank);
    for (int unsigned i = 1; i < eff_w * eff_h; i++)
      frame_px.push_back(($urandom_range(99) < pct) ? blank : epnf_pkg::pix_t'($urandom));
  endtask

  // Pixels, then eff_w + 1 drain items. With noise, stray flushes land among
  // the pixels (dropped) and some drain items are plain pixels (act as flush).
  task automatic run_frame(bit noise);
    for (int i = 0; i < frame_px.size(); i++) begin
      if (noise && $urandom_range(15) == 0)
        send_item('{epnf_pkg::pix_t'($urandom), 1'b1});
      send_item('{frame_px[i], 1'b0});
    end
    for (int unsigned i = 0; i <= eff_w; i++)
      send_item('{epnf_pkg::pix_t'($urandom), !(noise && $urandom_range(3) == 0)});
    frames_sent++;
  endtask

  // Small random frames under one stall mix; size changes on some frames only,
  // so other frames start right behind the previous drain.
  task automatic run_phase(int tx, int rx);
    int          start;
    bit          first;
    int unsigned w_pick;
    tx_idle_pct = tx;
    rx_idle_pct = rx;
    start = items_sent;
    first = 1'b1;
    while (items_sent - start < PHASE_ITEMS) begin
      if (first || $urandom_range(1) == 1) begin
        case ($urandom_range(9))
          0:       w_pick = 0;
          9:       w_pick = $urandom_range(9, 16);
          default: w_pick = $urandom_range(1, 8);
        endcase
        set_size(w_pick, $urandom_range(0, 6));
      end
      first = 1'b0;
      make_frame(fill_mix[$urandom_range(3)]);
      run_frame(1'b1);
    end
  endtask

  initial begin
    rst_n     <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_idx   <= epnf_pkg::CFG_FRAME_WIDTH;
    cfg_wdata <= '0;
    in_valid  <= 1'b0;
    in_item   <= '0;
    out_stall <= 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: zero sizes clamp to a 1x1 frame; a flush before the first
    // pixel of a frame is dropped.
    set_size(0, 0);
    send_item('{8'h00, 1'b1});
    frame_px = '{8'hFF};
    run_frame(1'b0);

    // 3x3: mostly blank border around values, extremes 00 and FF, fills from
    // several directions
    set_size(3, 3);
    frame_px = '{8'h00, 8'h00, 8'hA5, 8'h00, 8'hFF, 8'h00, 8'h3C, 8'h00, 8'h00};
    run_frame(1'b0);

    // 2x2: flush mid-frame is dropped, a pixel item during drain acts as flush
    set_size(2, 2);
    send_item('{8'h5A, 1'b0});
    send_item('{8'h5A, 1'b0});
    send_item('{8'hC3, 1'b1});
    send_item('{8'h00, 1'b0});
    send_item('{8'h5A, 1'b0});
    send_item('{8'hE7, 1'b1});
    send_item('{8'h81, 1'b0});
    send_item('{8'h3C, 1'b1});
    frames_sent++;

    // random frames under three stall mixes
    run_phase(35, 55);
    run_phase(55, 35);
    run_phase(0, 0);

    wait_idle();
    repeat (SETTLE) @(posedge clk);

    $display("summary: %0d items over %0d frames, %0d output pixels compared",
             items_sent, frames_sent, checked);
    $display("summary: frames 1x1 up to 16x6, zero sizes, %s",
             "dropped flushes, drain pixels, three stall mixes");
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/epnf_pkg.sv
hdl/epnf_ctrl.sv
hdl/epnf_lbuf.sv
hdl/epnf_fill.sv
hdl/empty_pixel_neighbor_fill.sv
tb/sv/fill_checker.sv
tb/sv/tb.sv
